// ----- src/trqs_pkg.sv -----
// Shared types and constants of the task ready-queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package trqs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int MAX_SEMS  = 8;
    localparam int TID_W     = 4;
    localparam int SEM_W     = 3;
    localparam int QIDX_W    = 4;
    localparam int CNT_W     = 5;
    localparam int SCNT_W    = 4;
    localparam int HANDLE_W  = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam logic [QIDX_W-1:0] READY_Q = QIDX_W'(MAX_SEMS);

    typedef enum logic [2:0] {
        FN_REGISTER = 3'd0,
        FN_CREATE   = 3'd1,
        FN_DISPATCH = 3'd2,
        FN_DONE     = 3'd3,
        FN_SLEEP    = 3'd4,
        FN_WAKE     = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOTHING = 3'd1,
        ST_FULL    = 3'd2,
        ST_NO_SEM  = 3'd3,
        ST_NO_RUN  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MD_UNUSED = 2'd0,
        MD_READY  = 2'd1,
        MD_RUN    = 2'd2,
        MD_WAIT   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQUEUE,
        S_CHECK,
        S_WALK,
        S_EXEC,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic requeue;
        logic walk;
        logic exec;
        logic emit;
    } trqs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_idle;
        logic walk_last;
        logic out_free;
    } trqs_sts_t;

endpackage
`default_nettype wire

// ----- src/task_ready_queue_scheduler_unit.sv -----
// Top level of the task ready-queue scheduler.
//
//  Channel  | Direction | Payload
//  s_axis   | in        | tuser: func; tdata: sem_index, task_handle
//  m_axis   | out       | tuser: status; tdata: task_id .. sleeping_total
//
// One event at a time: the next input transfer is accepted only after the result
// of the previous one has been loaded into the output register; a dispatch that
// has to wake all waiters first moves the wait queue of each created semaphore onto
// the ready queue. The result sits in an output register, so a stalled result only
// holds the next event in its last step.
// Reset is asynchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module task_ready_queue_scheduler_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [2:0]  s_axis_tuser,   // func
    input  wire  [23:0] s_axis_tdata,   // sem_index[2:0], task_handle[18:3], zeros
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [2:0]  m_axis_tuser,   // status
    output logic [39:0] m_axis_tdata    // task_id, out_handle, task_valid, sem_id,
                                        // idle_ran, released_mask, sleeping_total
);
    import trqs_pkg::*;

    trqs_cmd_t cmd;
    trqs_sts_t sts;

    trqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    trqs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_func    (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- src/trqs_ctrl.sv -----
// Controller state machine of the task ready-queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
module trqs_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  trqs_pkg::trqs_sts_t  sts,
    output trqs_pkg::trqs_cmd_t  cmd
);
    import trqs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_REQUEUE;
                end
            end
            S_REQUEUE:
            begin
                cmd.requeue = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sts.need_idle ? S_WALK : S_EXEC;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/trqs_dp.sv -----
// Datapath of the task ready-queue scheduler: task table, linked queues, result.
`timescale 1ns / 1ps
`default_nettype none
module trqs_dp (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire  [2:0]                          in_func,
    input  wire  [trqs_pkg::IN_DATA_W-1:0]      in_data,
    input  trqs_pkg::trqs_cmd_t                 cmd,
    output trqs_pkg::trqs_sts_t                 sts,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [2:0]                          out_status,
    output logic [trqs_pkg::OUT_DATA_W-1:0]     out_data
);
    import trqs_pkg::*;

    // Task table and queues.
    logic [HANDLE_W-1:0] body_reg  [MAX_TASKS];
    mode_t               mode_reg  [MAX_TASKS];
    logic [TID_W-1:0]    link_reg  [MAX_TASKS];
    logic [TID_W-1:0]    qfirst_reg[MAX_SEMS+1];
    logic [TID_W-1:0]    qlast_reg [MAX_SEMS+1];
    logic [CNT_W-1:0]    qlen_reg  [MAX_SEMS+1];

    logic                cur_valid_reg;
    logic [TID_W-1:0]    cur_reg;
    logic [CNT_W-1:0]    sleepers_reg;
    logic [CNT_W-1:0]    tasks_reg;
    logic [SCNT_W-1:0]   sems_reg;

    // Current event and its result.
    logic [2:0]          func_reg;
    logic [SEM_W-1:0]    sem_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [SEM_W-1:0]    walk_reg;
    logic [2:0]          status_reg;
    logic                named_reg;
    logic [TID_W-1:0]    tid_reg;
    logic [SEM_W-1:0]    semid_reg;
    logic                idle_reg;
    logic [MAX_SEMS-1:0] rel_reg;
    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Combinational event decode.
    logic                push_en;
    logic [QIDX_W-1:0]   push_q;
    logic [TID_W-1:0]    push_id;
    logic                pop_en;
    logic [QIDX_W-1:0]   pop_q;
    logic [TID_W-1:0]    pop_id;
    logic                mode_we;
    logic [TID_W-1:0]    mode_idx;
    mode_t               mode_val;
    logic [2:0]          status_next;
    logic                named_next;
    logic [TID_W-1:0]    tid_next;
    logic [SEM_W-1:0]    semid_next;
    logic                cur_valid_next;
    logic [TID_W-1:0]    cur_next;
    logic [CNT_W-1:0]    sleepers_next;
    logic [CNT_W-1:0]    tasks_next;
    logic [SCNT_W-1:0]   sems_next;
    logic                body_we;
    logic [QIDX_W-1:0]   sem_q;
    logic [QIDX_W-1:0]   walk_q;
    logic                sem_bad;

    assign sem_q   = {1'b0, sem_reg};
    assign walk_q  = {1'b0, walk_reg};
    assign sem_bad = ({1'b0, sem_reg} >= sems_reg);
    assign pop_id  = qfirst_reg[pop_q];

    assign sts.need_idle = (func_reg == FN_DISPATCH) && (qlen_reg[READY_Q] == '0)
                           && (sleepers_reg != '0);
    assign sts.walk_last = (SCNT_W'(walk_reg) + SCNT_W'(1)) >= sems_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Decode of the requeue step and the main event step.
    always_comb
    begin
        push_en        = 1'b0;
        push_q         = READY_Q;
        push_id        = cur_reg;
        pop_en         = 1'b0;
        pop_q          = READY_Q;
        mode_we        = 1'b0;
        mode_idx       = cur_reg;
        mode_val       = MD_READY;
        status_next    = ST_NOTHING;
        named_next     = 1'b0;
        tid_next       = '0;
        semid_next     = '0;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        sleepers_next  = sleepers_reg;
        tasks_next     = tasks_reg;
        sems_next      = sems_reg;
        body_we        = 1'b0;
        if (cmd.requeue)
        begin
            if ((func_reg == FN_DISPATCH) && cur_valid_reg && (mode_reg[cur_reg] == MD_RUN))
            begin
                push_en = 1'b1;
                mode_we = 1'b1;
            end
        end
        else if (cmd.exec)
        begin
            case (func_reg)
                FN_REGISTER:
                begin
                    if (tasks_reg >= CNT_W'(MAX_TASKS))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        tid_next    = tasks_reg[TID_W-1:0];
                        tasks_next  = tasks_reg + CNT_W'(1);
                        body_we     = 1'b1;
                        push_en     = 1'b1;
                        push_id     = tid_next;
                        mode_we     = 1'b1;
                        mode_idx    = tid_next;
                        named_next  = 1'b1;
                        status_next = ST_OK;
                    end
                end
                FN_CREATE:
                begin
                    if (sems_reg >= SCNT_W'(MAX_SEMS))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        semid_next  = sems_reg[SEM_W-1:0];
                        sems_next   = sems_reg + SCNT_W'(1);
                        status_next = ST_OK;
                    end
                end
                FN_DISPATCH:
                begin
                    cur_valid_next = 1'b0;
                    if (qlen_reg[READY_Q] != '0)
                    begin
                        pop_en         = 1'b1;
                        tid_next       = pop_id;
                        mode_we        = 1'b1;
                        mode_idx       = pop_id;
                        mode_val       = MD_RUN;
                        cur_next       = pop_id;
                        cur_valid_next = 1'b1;
                        named_next     = 1'b1;
                        status_next    = ST_OK;
                    end
                end
                FN_DONE:
                begin
                    if (!cur_valid_reg)
                    begin
                        status_next = ST_NO_RUN;
                    end
                    else
                    begin
                        tid_next       = cur_reg;
                        if (mode_reg[cur_reg] == MD_RUN)
                        begin
                            push_en = 1'b1;
                            mode_we = 1'b1;
                        end
                        cur_valid_next = 1'b0;
                        named_next     = 1'b1;
                        status_next    = ST_OK;
                    end
                end
                FN_SLEEP:
                begin
                    if (sem_bad)
                    begin
                        status_next = ST_NO_SEM;
                    end
                    else if (!cur_valid_reg || (mode_reg[cur_reg] != MD_RUN))
                    begin
                        status_next = ST_NO_RUN;
                    end
                    else
                    begin
                        tid_next      = cur_reg;
                        mode_we       = 1'b1;
                        mode_val      = MD_WAIT;
                        push_en       = 1'b1;
                        push_q        = sem_q;
                        sleepers_next = sleepers_reg + CNT_W'(1);
                        named_next    = 1'b1;
                        status_next   = ST_OK;
                    end
                end
                FN_WAKE:
                begin
                    if (sleepers_reg == '0)
                    begin
                        status_next = ST_NOTHING;
                    end
                    else if (sem_bad)
                    begin
                        status_next = ST_NO_SEM;
                    end
                    else if (qlen_reg[sem_q] == '0)
                    begin
                        status_next = ST_NOTHING;
                    end
                    else
                    begin
                        pop_en        = 1'b1;
                        pop_q         = sem_q;
                        tid_next      = pop_id;
                        push_en       = 1'b1;
                        push_id       = pop_id;
                        mode_we       = 1'b1;
                        mode_idx      = pop_id;
                        sleepers_next = sleepers_reg - CNT_W'(1);
                        named_next    = 1'b1;
                        status_next   = ST_OK;
                    end
                end
                default:
                begin
                    status_next = ST_NOTHING;
                end
            endcase
        end
    end

    // Queue storage with no defined reset: heads, tails, links and bodies.
    always_ff @(posedge clk)
    begin
        if (cmd.walk && (qlen_reg[walk_q] != '0))
        begin
            if (qlen_reg[READY_Q] == '0)
            begin
                qfirst_reg[READY_Q] <= qfirst_reg[walk_q];
            end
            else
            begin
                link_reg[qlast_reg[READY_Q]] <= qfirst_reg[walk_q];
            end
            qlast_reg[READY_Q] <= qlast_reg[walk_q];
        end
        if (pop_en)
        begin
            qfirst_reg[pop_q] <= link_reg[pop_id];
        end
        if (push_en)
        begin
            if (qlen_reg[push_q] == '0)
            begin
                qfirst_reg[push_q] <= push_id;
            end
            else
            begin
                link_reg[qlast_reg[push_q]] <= push_id;
            end
            qlast_reg[push_q] <= push_id;
        end
        if (body_we)
        begin
            body_reg[tid_next] <= handle_reg;
        end
    end

    // Queue lengths, task modes and scheduler counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= MAX_SEMS; i++)
            begin
                qlen_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                mode_reg[i] <= MD_UNUSED;
            end
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            sleepers_reg  <= '0;
            tasks_reg     <= '0;
            sems_reg      <= '0;
        end
        else
        begin
            if (cmd.walk)
            begin
                // Move one wait queue onto the ready queue.
                qlen_reg[READY_Q] <= qlen_reg[READY_Q] + qlen_reg[walk_q];
                qlen_reg[walk_q]  <= '0;
                if (sts.walk_last)
                begin
                    for (int i = 0; i < MAX_TASKS; i++)
                    begin
                        if (mode_reg[i] == MD_WAIT)
                        begin
                            mode_reg[i] <= MD_READY;
                        end
                    end
                    sleepers_reg <= '0;
                end
            end
            else
            begin
                if (pop_en)
                begin
                    qlen_reg[pop_q] <= qlen_reg[pop_q] - CNT_W'(1);
                end
                if (push_en)
                begin
                    qlen_reg[push_q] <= qlen_reg[push_q] + CNT_W'(1);
                end
                if (mode_we)
                begin
                    mode_reg[mode_idx] <= mode_val;
                end
                cur_valid_reg <= cur_valid_next;
                cur_reg       <= cur_next;
                sleepers_reg  <= sleepers_next;
                tasks_reg     <= tasks_next;
                sems_reg      <= sems_next;
            end
        end
    end

    // Event capture, walk index and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_func;
            sem_reg    <= in_data[SEM_W-1:0];
            handle_reg <= in_data[SEM_W +: HANDLE_W];
            walk_reg   <= '0;
            idle_reg   <= 1'b0;
            rel_reg    <= '0;
        end
        if (cmd.walk)
        begin
            idle_reg          <= 1'b1;
            rel_reg[walk_reg] <= 1'b1;
            walk_reg          <= walk_reg + SEM_W'(1);
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            named_reg  <= named_next;
            tid_reg    <= tid_next;
            semid_reg  <= semid_next;
        end
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= {2'b00, sleepers_reg, rel_reg, idle_reg, semid_reg, named_reg,
                               (named_reg ? body_reg[tid_reg] : HANDLE_W'(0)), tid_reg};
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;

endmodule
`default_nettype wire

// ----- src/trqs_checker.sv -----
// Port-level checks of the task ready-queue scheduler and their binding.
`timescale 1ns / 1ps
`default_nettype none
module trqs_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [2:0]  m_axis_tuser,
    input wire [39:0] m_axis_tdata
);
    import trqs_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // A named task only comes with an ok status.
    a_named_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tuser == ST_OK)
        else $error("task named on a failed event");

    // Idle always ends in a successful dispatch of a task.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[20] && m_axis_tdata[32:25] != 8'd0)
        else $error("idle result without a dispatched task");

    // An accepted event blocks the next one for the following cycle.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("event accepted while one is in work");

endmodule

bind task_ready_queue_scheduler_unit trqs_checker u_trqs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
